@@ sv/dvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvrt_pkg: shared definitions for the distance-vector route table
// Table depth, field widths, entry layout, and the kind, status, register
// and state codes used by the route table core.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int HOP_INC_RESET = 1;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W = 32;
    localparam int COST_W = 16;
    localparam int HOP_W  = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INFINITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP      = 1'd1;

    localparam logic [COST_W-1:0] INFINITY_RESET = 16'd16;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] gateway;
        logic [COST_W-1:0] cost;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        KIND_ADVERT,
        KIND_DOWN,
        KIND_EXPORT,
        KIND_LOOKUP
    } t_kind;

    typedef enum logic [3:0] {
        STAT_ADDED        = 4'd0,
        STAT_REPLACED     = 4'd1,
        STAT_DISCARDED    = 4'd2,
        STAT_SKIPPED      = 4'd3,
        STAT_FULL         = 4'd4,
        STAT_DOWN_DONE    = 4'd5,
        STAT_EXPORT_ENTRY = 4'd6,
        STAT_EXPORT_EMPTY = 4'd7,
        STAT_HIT          = 4'd8,
        STAT_MISS         = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

@@ sv/distance_vector_route_table_core.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_table_core: RIP-style route table with slot scanner
// Holds TABLE_DEPTH routes and serves advertised routes, interface-down
// poisoning, split-horizon export and cost lookups by scanning every slot.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low.
// Every command except a skipped self-route walks the whole table through a
// single RAM read port, one slot per cycle, so it holds busy while it reads
// every slot, waits for the last read data and finishes in ST_DONE. An
// external route whose destination equals the receiving interface is
// answered in the cycle after it is taken and never raises busy. Results
// come out as beats on o_valid, each present for exactly one cycle, with
// o_last marking the final beat of a command; the receiver has no way to
// stall, so it must take every beat. An export produces one beat per valid
// slot in slot order, the last one in ST_DONE, or one empty beat if no slot
// is valid. The slot valid marks are flip-flops cleared by reset, so the
// table is ready right after reset with no clearing pass. Configuration
// writes on i_cfg_we take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module distance_vector_route_table_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_kind,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_dest_address,
    input  logic [dvrt_pkg::COST_W-1:0]     i_route_cost_in,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_peer,
    input  logic                            i_is_internal,

    output logic                            o_valid,
    output logic [3:0]                      o_status,
    output logic                            o_fwd_write,
    output logic [dvrt_pkg::ADDR_W-1:0]     o_route_address,
    output logic [dvrt_pkg::ADDR_W-1:0]     o_route_next_hop,
    output logic [dvrt_pkg::COST_W-1:0]     o_route_cost,
    output logic                            o_last
);

    import dvrt_pkg::*;

    // Configuration registers.
    logic [COST_W-1:0] r_inf;
    logic [HOP_W-1:0]  r_hop;

    // Sequencer state and the latched command.
    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [ADDR_W-1:0]  r_key, n_key;
    logic [ADDR_W-1:0]  r_peer, n_peer;
    logic [COST_W-1:0]  r_cost_new, n_cost_new;
    logic               r_internal, n_internal;

    // Scan counters: r_cnt is the slot being read, r_rd_idx the slot whose
    // data is on the RAM output this cycle.
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;

    logic [TABLE_DEPTH-1:0] r_slot_valid, n_slot_valid;

    // Scan results.
    logic               r_match_found, n_match_found;
    logic [IDX_W-1:0]   r_match_idx, n_match_idx;
    logic [ADDR_W-1:0]  r_match_nh, n_match_nh;
    logic [COST_W-1:0]  r_match_cost, n_match_cost;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;

    // Export entry held back one slot so the final one can carry last.
    logic               r_hold_vld, n_hold_vld;
    t_entry             r_hold, n_hold;

    // Output beat registers.
    logic               r_out_vld, n_out_vld;
    t_status            r_out_status, n_out_status;
    logic               r_out_fwd, n_out_fwd;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [ADDR_W-1:0]  r_out_nh, n_out_nh;
    logic [COST_W-1:0]  r_out_cost, n_out_cost;
    logic               r_out_last, n_out_last;

    // RAM ports.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    t_entry             w_rdata;

    // Shared slot compare unit and command decode.
    logic               w_accept;
    logic               w_skip;
    logic [COST_W:0]    w_sum;
    logic [COST_W-1:0]  w_ext_cost;
    logic               w_slot_vld;
    logic               w_addr_eq_key;
    logic               w_addr_eq_peer;
    logic               w_nh_eq_peer;
    logic               w_scan_end;
    logic               w_replace;
    logic [COST_W-1:0]  w_export_cost;

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_skip   = (t_kind'(i_kind) == KIND_ADVERT) && !i_is_internal &&
                      (i_dest_address == i_peer);

    // External cost saturates at the unreachable value; the sum is one bit
    // wider so it never wraps.
    assign w_sum      = {1'b0, i_route_cost_in} + {{(COST_W + 1 - HOP_W){1'b0}}, r_hop};
    assign w_ext_cost = (w_sum > {1'b0, r_inf}) ? r_inf : w_sum[COST_W-1:0];

    assign w_slot_vld     = r_rd_vld && r_slot_valid[r_rd_idx];
    assign w_addr_eq_key  = (w_rdata.address == r_key);
    assign w_addr_eq_peer = (w_rdata.address == r_peer);
    assign w_nh_eq_peer   = (w_rdata.gateway == r_peer);
    assign w_scan_end     = (r_cnt == CNT_W'(TABLE_DEPTH));
    assign w_export_cost  = (w_nh_eq_peer && (w_rdata.cost != '0)) ? r_inf : w_rdata.cost;

    assign w_replace = (r_match_cost > r_cost_new) || r_internal || (r_match_nh == r_peer);

    assign w_raddr = r_cnt[IDX_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && !w_skip) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result beats.
    always_comb begin
        n_kind        = r_kind;
        n_key         = r_key;
        n_peer        = r_peer;
        n_cost_new    = r_cost_new;
        n_internal    = r_internal;
        n_cnt         = r_cnt;
        n_rd_vld      = 1'b0;
        n_rd_idx      = r_rd_idx;
        n_slot_valid  = r_slot_valid;
        n_match_found = r_match_found;
        n_match_idx   = r_match_idx;
        n_match_nh    = r_match_nh;
        n_match_cost  = r_match_cost;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_hold_vld    = r_hold_vld;
        n_hold        = r_hold;
        n_out_vld     = 1'b0;
        n_out_status  = r_out_status;
        n_out_fwd     = r_out_fwd;
        n_out_addr    = r_out_addr;
        n_out_nh      = r_out_nh;
        n_out_cost    = r_out_cost;
        n_out_last    = r_out_last;
        w_we          = 1'b0;
        w_waddr       = r_rd_idx;
        w_wdata       = w_rdata;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind        = t_kind'(i_kind);
                    n_key         = (t_kind'(i_kind) == KIND_DOWN) ? i_peer : i_dest_address;
                    n_peer        = i_peer;
                    n_internal    = i_is_internal;
                    n_cost_new    = i_is_internal ? i_route_cost_in : w_ext_cost;
                    n_cnt         = '0;
                    n_match_found = 1'b0;
                    n_free_found  = 1'b0;
                    n_hold_vld    = 1'b0;
                    if (w_skip) begin
                        n_out_vld    = 1'b1;
                        n_out_status = STAT_SKIPPED;
                        n_out_fwd    = 1'b0;
                        n_out_addr   = i_dest_address;
                        n_out_nh     = '0;
                        n_out_cost   = '0;
                        n_out_last   = 1'b1;
                    end
                end
            end

            ST_SCAN: begin
                if (!w_scan_end) begin
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    if (!w_slot_vld && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                    if (w_slot_vld && w_addr_eq_key && !r_match_found) begin
                        n_match_found = 1'b1;
                        n_match_idx   = r_rd_idx;
                        n_match_nh    = w_rdata.gateway;
                        n_match_cost  = w_rdata.cost;
                    end
                    if ((r_kind == KIND_DOWN) && w_slot_vld && !w_addr_eq_peer &&
                        w_nh_eq_peer) begin
                        w_we         = 1'b1;
                        w_waddr      = r_rd_idx;
                        w_wdata.cost = r_inf;
                    end
                    if ((r_kind == KIND_EXPORT) && w_slot_vld) begin
                        if (r_hold_vld) begin
                            n_out_vld    = 1'b1;
                            n_out_status = STAT_EXPORT_ENTRY;
                            n_out_fwd    = 1'b0;
                            n_out_addr   = r_hold.address;
                            n_out_nh     = r_hold.gateway;
                            n_out_cost   = r_hold.cost;
                            n_out_last   = 1'b0;
                        end
                        n_hold_vld       = 1'b1;
                        n_hold.address   = w_rdata.address;
                        n_hold.gateway   = w_rdata.gateway;
                        n_hold.cost      = w_export_cost;
                    end
                end
            end

            ST_DONE: begin
                n_out_vld  = 1'b1;
                n_out_fwd  = 1'b0;
                n_out_last = 1'b1;
                case (r_kind)
                    KIND_ADVERT: begin
                        n_out_addr = r_key;
                        n_out_nh   = r_peer;
                        n_out_cost = r_cost_new;
                        w_wdata.address  = r_key;
                        w_wdata.gateway  = r_peer;
                        w_wdata.cost     = r_cost_new;
                        if (r_match_found) begin
                            if (w_replace) begin
                                n_out_status = STAT_REPLACED;
                                n_out_fwd    = 1'b1;
                                w_we         = 1'b1;
                                w_waddr      = r_match_idx;
                            end else begin
                                n_out_status = STAT_DISCARDED;
                                n_out_nh     = r_match_nh;
                                n_out_cost   = r_match_cost;
                            end
                        end else if (r_free_found) begin
                            // A new route takes the lowest free slot.
                            n_out_status = STAT_ADDED;
                            n_out_fwd    = 1'b1;
                            w_we         = 1'b1;
                            w_waddr      = r_free_idx;
                            n_slot_valid[r_free_idx] = 1'b1;
                        end else begin
                            n_out_status = STAT_FULL;
                        end
                    end
                    KIND_DOWN: begin
                        n_out_status = STAT_DOWN_DONE;
                        n_out_addr   = r_peer;
                        n_out_nh     = '0;
                        n_out_cost   = '0;
                    end
                    KIND_EXPORT: begin
                        if (r_hold_vld) begin
                            n_out_status = STAT_EXPORT_ENTRY;
                            n_out_addr   = r_hold.address;
                            n_out_nh     = r_hold.gateway;
                            n_out_cost   = r_hold.cost;
                        end else begin
                            n_out_status = STAT_EXPORT_EMPTY;
                            n_out_addr   = '0;
                            n_out_nh     = '0;
                            n_out_cost   = '0;
                        end
                    end
                    KIND_LOOKUP: begin
                        n_out_addr = r_key;
                        if (r_match_found) begin
                            n_out_status = STAT_HIT;
                            n_out_nh     = r_match_nh;
                            n_out_cost   = r_match_cost;
                        end else begin
                            n_out_status = STAT_MISS;
                            n_out_nh     = '0;
                            n_out_cost   = '0;
                        end
                    end
                    default: begin
                        n_out_status = STAT_MISS;
                    end
                endcase
            end

            default: begin
                n_out_vld = 1'b0;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rd_vld     <= 1'b0;
            r_slot_valid <= '0;
            r_out_vld    <= 1'b0;
            r_inf        <= INFINITY_RESET;
            r_hop        <= HOP_W'(HOP_INC_RESET);
        end else begin
            r_state      <= n_state;
            r_rd_vld     <= n_rd_vld;
            r_slot_valid <= n_slot_valid;
            r_out_vld    <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INFINITY: r_inf <= i_cfg_data;
                    REG_HOP:      r_hop <= i_cfg_data[HOP_W-1:0];
                    default: begin
                        r_inf <= r_inf;
                    end
                endcase
            end
        end
    end

    // Payload and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_key         <= n_key;
        r_peer        <= n_peer;
        r_cost_new    <= n_cost_new;
        r_internal    <= n_internal;
        r_cnt         <= n_cnt;
        r_rd_idx      <= n_rd_idx;
        r_match_found <= n_match_found;
        r_match_idx   <= n_match_idx;
        r_match_nh    <= n_match_nh;
        r_match_cost  <= n_match_cost;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_hold_vld    <= n_hold_vld;
        r_hold        <= n_hold;
        r_out_status  <= n_out_status;
        r_out_fwd     <= n_out_fwd;
        r_out_addr    <= n_out_addr;
        r_out_nh      <= n_out_nh;
        r_out_cost    <= n_out_cost;
        r_out_last    <= n_out_last;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_valid          = r_out_vld;
    assign o_status         = r_out_status;
    assign o_fwd_write      = r_out_fwd;
    assign o_route_address  = r_out_addr;
    assign o_route_next_hop = r_out_nh;
    assign o_route_cost     = r_out_cost;
    assign o_last           = r_out_last;

    // A forwarding write only comes with an added or replaced route.
    a_fwd_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fwd_write) |->
            (o_status == STAT_ADDED || o_status == STAT_REPLACED))
        else $error("forwarding write on a beat that is not added or replaced");

    // Only export entries may be followed by more beats of the same command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_EXPORT_ENTRY) |-> o_last)
        else $error("non-export beat without last");

    // The finishing cycle always delivers the final beat of the command.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_valid && o_last))
        else $error("command finished without a last beat");

    // The table is only written while a command is being worked on.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_SCAN || r_state == ST_DONE))
        else $error("slot RAM written while idle");

    // A command that scans the table raises busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_skip) |=> busy)
        else $error("scan command taken without going busy");

endmodule

@@ sv/dvrt_ram.sv @@
// ----------------------------------------------------------------------------
// dvrt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
